[rtl/sliding_window_min_max_macros.svh]
// Assertion macros for the sliding window min/max block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef SLIDING_WINDOW_MIN_MAX_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/swmm_pkg.sv]
// Package for the sliding window min/max block: sample width and slot type.
// No dependencies.
`default_nettype none

package swmm_pkg;

    localparam int SAMPLE_W = 16;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t min_v;
        sample_t max_v;
    } slot_t;

endpackage

`default_nettype wire

[rtl/sliding_window_min_max.sv]
// Sliding window min/max: one beat in, one beat out, ring of slot pairs in one RAM.
// Each accepted beat starts a scan of k earlier slots, k = 1 .. WINDOW_DEPTH-1, read through
// the single RAM read port one slot a cycle into a running min/max, then registered out.
// No new beat is taken until the scan's result has moved into the output register.
// Reset: pointers, scan control and per-slot valid bits clear; invalid slots read zero.
// Depends on swmm_pkg and sliding_window_min_max_macros.svh.
`default_nettype none

`include "sliding_window_min_max_macros.svh"

module sliding_window_min_max
    import swmm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 10
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SAMPLE_W-1:0] block_min,
    input  wire logic [SAMPLE_W-1:0] block_max,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [SAMPLE_W-1:0]      window_min,
    output logic [SAMPLE_W-1:0]      window_max
);

    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    function automatic ptr_t ring_next(input ptr_t p);
        ptr_t n;
        if (p == PTR_W'(WINDOW_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    state_t                   state_reg;
    ptr_t                     wp_reg;
    ptr_t                     op_reg;
    ptr_t                     cur_reg;
    logic                     pend_reg;
    logic                     rd_valid_reg;
    slot_t                    rd_slot_reg;
    logic [WINDOW_DEPTH-1:0]  slot_valid_reg;
    sample_t                  run_min_reg;
    sample_t                  run_max_reg;
    logic                     out_valid_reg;
    sample_t                  window_min_reg;
    sample_t                  window_max_reg;

    slot_t                    mem [WINDOW_DEPTH];

    logic                     in_accept;
    ptr_t                     wp_adv;
    ptr_t                     op_adv;
    logic                     issue;
    logic                     scan_done;
    logic                     out_free;
    sample_t                  rd_min;
    sample_t                  rd_max;
    sample_t                  run_min_next;
    sample_t                  run_max_next;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign wp_adv     = ring_next(wp_reg);
    assign op_adv     = (wp_adv == op_reg) ? ring_next(op_reg) : op_reg;
    assign issue      = (state_reg == ST_SCAN) && (cur_reg != wp_reg);
    assign scan_done  = (state_reg == ST_SCAN) && !issue && !pend_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign rd_min     = rd_valid_reg ? rd_slot_reg.min_v : '0;
    assign rd_max     = rd_valid_reg ? rd_slot_reg.max_v : '0;

    assign out_valid  = out_valid_reg;
    assign window_min = window_min_reg;
    assign window_max = window_max_reg;

    always_comb
    begin
        run_min_next = run_min_reg;
        run_max_next = run_max_reg;
        if (in_accept)
        begin
            run_min_next = block_min;
            run_max_next = block_max;
        end
        else if (pend_reg)
        begin
            // zero in a min slot means empty
            if ((rd_min != '0) && (rd_min < run_min_reg))
            begin
                run_min_next = rd_min;
            end
            if (rd_max > run_max_reg)
            begin
                run_max_next = rd_max;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mem[wp_adv] <= '{min_v: block_min, max_v: block_max};
        end
        if (issue)
        begin
            rd_slot_reg <= mem[cur_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        run_min_reg <= run_min_next;
        run_max_reg <= run_max_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            op_reg         <= '0;
            cur_reg        <= '0;
            pend_reg       <= 1'b0;
            rd_valid_reg   <= 1'b0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            window_min_reg <= '0;
            window_max_reg <= '0;
        end
        else
        begin
            pend_reg <= issue;
            if (issue)
            begin
                rd_valid_reg <= slot_valid_reg[cur_reg];
                cur_reg      <= ring_next(cur_reg);
            end
            if (scan_done && out_free)
            begin
                out_valid_reg  <= 1'b1;
                window_min_reg <= run_min_reg;
                window_max_reg <= run_max_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        wp_reg                 <= wp_adv;
                        op_reg                 <= op_adv;
                        cur_reg                <= op_adv;
                        slot_valid_reg[wp_adv] <= 1'b1;
                        state_reg              <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_done && out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `SWMM_ASSERT_NOW(a_ptr_range,
        1'b1,
        (wp_reg <= PTR_W'(WINDOW_DEPTH - 1)) && (op_reg <= PTR_W'(WINDOW_DEPTH - 1)),
        "ring pointer out of range")
    `SWMM_ASSERT_NEXT(a_ring_gap, in_accept, wp_reg != op_reg,
        "write pointer caught the oldest pointer after a beat")
    `SWMM_ASSERT_NEXT(a_no_overwrite, scan_done && out_valid_reg && !out_ready,
        (state_reg == ST_SCAN) && out_valid_reg,
        "pending result overwritten")
    `SWMM_ASSERT_NOW(a_scan_skips_head, issue, slot_valid_reg[wp_reg],
        "scan running while the new slot is not marked valid")

endmodule

`default_nettype wire
